### rtl/swtp_pkg.sv
`timescale 1ns / 1ps

package swtp_pkg;

    // Number of slots, slot 0 included. Slot 0 is reserved and never handed out.
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FREE_W = $clog2(SLOTS);
    localparam int ID_W   = 8;
    localparam int CNT_W  = 16;

    localparam logic [ID_W-1:0] ID_BASE = ID_W'(100);

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd            cmd;
        logic [ID_W-1:0] timer_id;
    } t_item;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] value;
    } t_reply;

    typedef struct packed {
        logic [SLOTS-1:0]  active;
        logic [FREE_W-1:0] free_cnt;
    } t_status;

endpackage

### rtl/swtp_in_stage.sv
`timescale 1ns / 1ps

// Input register. It refills in the same cycle it is drained.
module swtp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_timer_id,
    output logic                o_in_stall,
    input  logic                i_consume,
    output logic                o_valid,
    output swtp_pkg::t_item     o_item
);

    logic            r_valid;
    logic            n_valid;
    swtp_pkg::t_item r_item;
    logic            w_load;

    assign o_in_stall = r_valid && !i_consume;
    assign w_load     = i_in_valid && !o_in_stall;
    assign n_valid    = w_load || (r_valid && !i_consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd      <= swtp_pkg::t_cmd'(i_cmd);
            r_item.timer_id <= i_timer_id;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/swtp_core.sv
`timescale 1ns / 1ps

// Slot state and the combinational request logic.
module swtp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  swtp_pkg::t_item   i_item,
    output swtp_pkg::t_reply  o_reply,
    output swtp_pkg::t_status o_status
);

    logic [swtp_pkg::SLOTS-1:0]  r_active;
    logic [swtp_pkg::SLOTS-1:0]  n_active;
    logic [swtp_pkg::FREE_W-1:0] r_free;
    logic [swtp_pkg::FREE_W-1:0] n_free;
    logic [swtp_pkg::CNT_W-1:0]  r_count [swtp_pkg::SLOTS];
    logic [swtp_pkg::CNT_W-1:0]  n_count [swtp_pkg::SLOTS];

    logic [swtp_pkg::ID_W-1:0]   w_diff;
    logic [swtp_pkg::SLOT_W-1:0] w_slot;
    logic                        w_hit;
    logic [swtp_pkg::SLOT_W-1:0] w_free_idx;
    logic                        w_can_begin;

    // Id to slot: in range when the offset from the id base is below SLOTS.
    assign w_diff = i_item.timer_id - swtp_pkg::ID_BASE;
    assign w_slot = w_diff[swtp_pkg::SLOT_W-1:0];
    assign w_hit  = (i_item.timer_id >= swtp_pkg::ID_BASE)
                 && (w_diff < swtp_pkg::ID_W'(swtp_pkg::SLOTS))
                 && r_active[w_slot];

    // Lowest inactive slot above the reserved one.
    always_comb begin
        w_free_idx = '0;
        for (int i = swtp_pkg::SLOTS - 1; i >= 1; i--) begin
            if (!r_active[i]) begin
                w_free_idx = swtp_pkg::SLOT_W'(i);
            end
        end
    end

    assign w_can_begin = (r_free != '0);

    always_comb begin
        n_active      = r_active;
        n_free        = r_free;
        n_count       = r_count;
        o_reply.valid = 1'b0;
        o_reply.value = '0;
        if (i_fire) begin
            case (i_item.cmd)
                swtp_pkg::CMD_TICK: begin
                    for (int i = 0; i < swtp_pkg::SLOTS; i++) begin
                        if (r_active[i]) begin
                            n_count[i] = r_count[i] + 1'b1;
                        end
                    end
                end
                swtp_pkg::CMD_BEGIN: begin
                    o_reply.valid = 1'b1;
                    if (w_can_begin) begin
                        n_active[w_free_idx] = 1'b1;
                        n_count[w_free_idx]  = '0;
                        n_free               = r_free - 1'b1;
                        o_reply.value        = swtp_pkg::CNT_W'(swtp_pkg::ID_BASE)
                                             + swtp_pkg::CNT_W'(w_free_idx);
                    end
                end
                swtp_pkg::CMD_CHECK, swtp_pkg::CMD_RELEASE: begin
                    o_reply.valid = 1'b1;
                    if (w_hit) begin
                        o_reply.value = r_count[w_slot];
                        if (i_item.cmd == swtp_pkg::CMD_RELEASE) begin
                            n_active[w_slot] = 1'b0;
                            n_count[w_slot]  = '0;
                            n_free           = r_free + 1'b1;
                        end
                    end
                end
                default: begin
                    o_reply.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_free   <= swtp_pkg::FREE_W'(swtp_pkg::SLOTS - 1);
            for (int i = 0; i < swtp_pkg::SLOTS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_active <= n_active;
            r_free   <= n_free;
            r_count  <= n_count;
        end
    end

    assign o_status.active   = r_active;
    assign o_status.free_cnt = r_free;

endmodule

### rtl/swtp_out_stage.sv
`timescale 1ns / 1ps

// Result register. It takes a new reply whenever it is empty or being drained.
module swtp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swtp_pkg::t_reply i_reply,
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [15:0]      o_reply_value
);

    logic        r_valid;
    logic        n_valid;
    logic [15:0] r_value;
    logic        w_load;

    assign o_ready = !r_valid || !i_out_stall;
    assign w_load  = o_ready && i_reply.valid;
    assign n_valid = o_ready ? i_reply.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value <= i_reply.value;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_reply_value = r_value;

endmodule

### rtl/stopwatch_timer_pool.sv
`timescale 1ns / 1ps

// Pool of millisecond stopwatch slots with ids 100 + slot; slot 0 is reserved.
// Input channel: i_in_valid / o_in_stall carry one request beat with i_cmd
// (tick, begin, check, release) and i_timer_id. Output channel: o_out_valid /
// i_out_stall carry one reply beat in o_reply_value for every begin, check
// and release; a tick updates the counts and sends no reply.
// A beat is registered on entry, then decoded and applied to the slot state
// from the input register while its reply is registered in the result
// register. One beat is taken every cycle while o_in_stall is low; the
// state update of a beat is visible to the beat right behind it.
// When the receiver stalls, the result register holds its reply. A request
// that would produce a reply then waits in the input register and o_in_stall
// rises; ticks keep draining since they need no result slot.
// Synchronous active-low reset frees every slot, zeroes all counts and empties
// both registers.
module stopwatch_timer_pool (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_timer_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_reply_value
);

    logic                     w_req_valid;
    swtp_pkg::t_item          w_req;
    logic                     w_out_ready;
    logic                     w_fire;
    swtp_pkg::t_reply         w_reply;
    swtp_pkg::t_status        w_status;

    swtp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_timer_id (i_timer_id),
        .o_in_stall (o_in_stall),
        .i_consume  (w_fire),
        .o_valid    (w_req_valid),
        .o_item     (w_req)
    );

    // A tick never needs the result register; every other command does.
    assign w_fire = w_req_valid && ((w_req.cmd == swtp_pkg::CMD_TICK) || w_out_ready);

    swtp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_req),
        .o_reply  (w_reply),
        .o_status (w_status)
    );

    swtp_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_reply       (w_reply),
        .o_ready       (w_out_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reply_value (o_reply_value)
    );

    // The free count always mirrors the number of inactive handout slots.
    a_free_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_status.active) + int'(w_status.free_cnt)) == (swtp_pkg::SLOTS - 1))
        else $error("free slot count disagrees with active bits");

    // The reserved slot is never handed out.
    a_slot0_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.active[0])
        else $error("reserved slot became active");

    // The input side stalls only for a waiting reply-producing request.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_req_valid && (w_req.cmd != swtp_pkg::CMD_TICK)
                        && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked reply");

    // A tick never produces a reply beat.
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_req.cmd == swtp_pkg::CMD_TICK)) |-> !w_reply.valid)
        else $error("tick produced a reply");

endmodule
